// ===== hdl/phcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package phcr_pkg;

  // fraction bits of the fractional cube coordinates
  localparam int FRAC_BITS = 16;

  localparam int PT_W   = 32;
  localparam int PT_FRAC = 8;
  localparam int COEF_W = 30;
  localparam int INV_W  = 24;
  localparam int INV_FRAC = 16;
  localparam int RAD_W  = 15;
  localparam int OUT_W  = 16;

  // unsigned Q0.30 coefficients
  localparam logic [COEF_W-1:0] K_SQRT3_THIRD = 30'd619925131;
  localparam logic [COEF_W-1:0] K_ONE_THIRD   = 30'd357913941;
  localparam logic [COEF_W-1:0] K_TWO_THIRDS  = 30'd715827883;

  localparam int PROD_W   = PT_W + COEF_W;            // signed point * coef
  localparam int MAG_W    = PROD_W - 1;               // magnitude of that
  localparam int LO_SPLIT = 24;                       // low slice of magnitude
  localparam int HI_W     = MAG_W - LO_SPLIT;
  localparam int LO_W     = LO_SPLIT + INV_W;
  localparam int SHIFT    = PT_FRAC + COEF_W + INV_FRAC - LO_SPLIT - FRAC_BITS;
  localparam int P_W      = MAG_W - SHIFT;            // scaled magnitude
  localparam int FR_W     = P_W + 1;                  // signed fq, fr
  localparam int SUM_W    = FR_W + 1;                 // signed fq + fr
  localparam int SMAG_W   = SUM_W - 1;                // magnitude of fs
  localparam int K_W      = SMAG_W - FRAC_BITS + 1;   // rounded magnitude
  localparam int RND_W    = K_W + 1;                  // signed rounded value
  localparam int HEX_W    = RND_W + 2;                // q, r after fix-up
  localparam int DIST_W   = HEX_W + 2;                // sum of magnitudes

  localparam int NUM_STAGES = 14;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = INV_W;

  localparam logic [INV_W-1:0] INV_RESET = 24'd65536;
  localparam logic [RAD_W-1:0] RAD_RESET = 15'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_TILE_SIZE = 2'd0,
    REG_GRID_RADIUS   = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [K_W-1:0]       k;
    logic [FRAC_BITS-1:0] err;
  } round_t;

endpackage

`default_nettype wire

// ===== hdl/phcr_mag_round.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Rounds a fixed-point magnitude half up and reports the absolute rounding error.
module phcr_mag_round import phcr_pkg::*; (
  input  wire logic [SMAG_W-1:0] mag_i,
  output round_t                 res_o
);

  logic [FRAC_BITS-1:0] frac;
  logic                 up;
  logic [FRAC_BITS-1:0] err_up;

  always_comb begin
    frac   = mag_i[FRAC_BITS-1:0];
    up     = frac[FRAC_BITS-1];
    // 1.0 - frac, frac is at least one half here
    err_up = -frac;
    res_o.k   = K_W'(mag_i[SMAG_W-1:FRAC_BITS]) + K_W'(up);
    res_o.err = up ? err_up : frac;
  end

endmodule

`default_nettype wire

// ===== hdl/pixel_to_hex_cube_round_core.sv =====
// Each input transaction passes through stages S1 to S14 and yields one result per input.
// Throughput: one transaction per cycle; a stalled output backs up the stage
// chain, and empty stages still fill while the output waits.
// Reset: stage valids cleared, inverse_tile_size = 1.0 (Q8.16), grid_radius = 8.
// Rate is set by the 14-stage multiply / round / distance pipeline.
`timescale 1ns / 1ps
`default_nettype none

module pixel_to_hex_cube_round_core import phcr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic signed [PT_W-1:0] point_x_i,
  input  wire logic signed [PT_W-1:0] point_y_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [OUT_W-1:0]    hex_q_o,
  output logic signed [OUT_W-1:0]    hex_r_o,
  output logic                       inside_grid_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NS = NUM_STAGES;

  // ---------------- configuration ----------------
  logic [INV_W-1:0] inv_q;
  logic [RAD_W-1:0] rad_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= INV_RESET;
      rad_q <= RAD_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_INV_TILE_SIZE: inv_q <= cfg_data_i;
        REG_GRID_RADIUS:   rad_q <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage control ----------------
  logic [NS:1] v_q;
  logic [NS:1] adv;
  logic [NS:0] v_src;

  // a stage loads when the output drains or it or any later stage holds a bubble
  for (genvar g = 1; g <= NS; g++) begin : g_adv
    assign adv[g] = ~out_stall_i | ~(&v_q[NS:g]);
  end

  assign in_stall_o  = ~adv[1];
  assign out_valid_o = v_q[NS];
  assign v_src       = {v_q, in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_src[k-1];
        end
      end
    end
  end

  // ---------------- S1: coefficient products ----------------
  logic signed [COEF_W:0]   c_sq3, c_one3, c_two3;
  logic signed [PROD_W-1:0] px_d, py1_d, py2_d, px_q, py1_q, py2_q;

  assign c_sq3  = signed'({1'b0, K_SQRT3_THIRD});
  assign c_one3 = signed'({1'b0, K_ONE_THIRD});
  assign c_two3 = signed'({1'b0, K_TWO_THIRDS});

  always_comb begin
    px_d  = PROD_W'(point_x_i) * PROD_W'(c_sq3);
    py1_d = PROD_W'(point_y_i) * PROD_W'(c_one3);
    py2_d = PROD_W'(point_y_i) * PROD_W'(c_two3);
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      px_q  <= px_d;
      py1_q <= py1_d;
      py2_q <= py2_d;
    end
  end

  // ---------------- S2: aq = sqrt3/3*x - 1/3*y, ar = 2/3*y ----------------
  logic signed [PROD_W-1:0] aq_q, ar_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      aq_q <= px_q - py1_q;
      ar_q <= py2_q;
    end
  end

  // ---------------- S3: sign / magnitude ----------------
  logic [PROD_W-1:0] naq, nar;
  logic [MAG_W-1:0]  mq_q, mr_q;
  logic              sq3_q, sr3_q;

  assign naq = -aq_q;
  assign nar = -ar_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      sq3_q <= aq_q[PROD_W-1];
      sr3_q <= ar_q[PROD_W-1];
      mq_q  <= aq_q[PROD_W-1] ? naq[MAG_W-1:0] : aq_q[MAG_W-1:0];
      mr_q  <= ar_q[PROD_W-1] ? nar[MAG_W-1:0] : ar_q[MAG_W-1:0];
    end
  end

  // ---------------- S4: split products with inverse tile size ----------------
  logic [MAG_W-1:0] hiq_d, hir_d, hiq_q, hir_q;
  logic [LO_W-1:0]  loq_d, lor_d, loq_q, lor_q;
  logic             sq4_q, sr4_q;

  always_comb begin
    hiq_d = MAG_W'(mq_q[MAG_W-1:LO_SPLIT]) * MAG_W'(inv_q);
    hir_d = MAG_W'(mr_q[MAG_W-1:LO_SPLIT]) * MAG_W'(inv_q);
    loq_d = LO_W'(mq_q[LO_SPLIT-1:0]) * LO_W'(inv_q);
    lor_d = LO_W'(mr_q[LO_SPLIT-1:0]) * LO_W'(inv_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      hiq_q <= hiq_d;
      hir_q <= hir_d;
      loq_q <= loq_d;
      lor_q <= lor_d;
      sq4_q <= sq3_q;
      sr4_q <= sr3_q;
    end
  end

  // ---------------- S5: truncated scaled magnitude ----------------
  logic [MAG_W-1:0] sumq, sumr;
  logic [P_W-1:0]   pq_q, pr_q;
  logic             sq5_q, sr5_q;

  assign sumq = hiq_q + MAG_W'(loq_q[LO_W-1:LO_SPLIT]);
  assign sumr = hir_q + MAG_W'(lor_q[LO_W-1:LO_SPLIT]);

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      pq_q  <= sumq[MAG_W-1:SHIFT];
      pr_q  <= sumr[MAG_W-1:SHIFT];
      sq5_q <= sq4_q;
      sr5_q <= sr4_q;
    end
  end

  // ---------------- S6: signed fq, fr and rounding of q, r ----------------
  logic signed [FR_W-1:0] fq_pos, fr_pos, fq_q, fr_q;
  round_t                 rq_d, rr_d, rq6_q, rr6_q;
  logic                   sq6_q, sr6_q;

  assign fq_pos = signed'({1'b0, pq_q});
  assign fr_pos = signed'({1'b0, pr_q});

  phcr_mag_round u_round_q (
    .mag_i (SMAG_W'(pq_q)),
    .res_o (rq_d)
  );

  phcr_mag_round u_round_r (
    .mag_i (SMAG_W'(pr_q)),
    .res_o (rr_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      fq_q  <= sq5_q ? -fq_pos : fq_pos;
      fr_q  <= sr5_q ? -fr_pos : fr_pos;
      rq6_q <= rq_d;
      rr6_q <= rr_d;
      sq6_q <= sq5_q;
      sr6_q <= sr5_q;
    end
  end

  // ---------------- S7: fq + fr ----------------
  logic signed [SUM_W-1:0] fsum_q;
  round_t                  rq7_q, rr7_q;
  logic                    sq7_q, sr7_q;

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      fsum_q <= SUM_W'(fq_q) + SUM_W'(fr_q);
      rq7_q  <= rq6_q;
      rr7_q  <= rr6_q;
      sq7_q  <= sq6_q;
      sr7_q  <= sr6_q;
    end
  end

  // ---------------- S8: magnitude of fs = -(fq + fr) ----------------
  logic [SUM_W-1:0]  nfsum;
  logic [SMAG_W-1:0] ms_q;
  logic              ss8_q;
  round_t            rq8_q, rr8_q;
  logic              sq8_q, sr8_q;

  assign nfsum = -fsum_q;

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      ms_q  <= fsum_q[SUM_W-1] ? nfsum[SMAG_W-1:0] : fsum_q[SMAG_W-1:0];
      ss8_q <= ~fsum_q[SUM_W-1];
      rq8_q <= rq7_q;
      rr8_q <= rr7_q;
      sq8_q <= sq7_q;
      sr8_q <= sr7_q;
    end
  end

  // ---------------- S9: rounding of s ----------------
  round_t rs_d, rs9_q, rq9_q, rr9_q;
  logic   ss9_q, sq9_q, sr9_q;

  phcr_mag_round u_round_s (
    .mag_i (ms_q),
    .res_o (rs_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      rs9_q <= rs_d;
      rq9_q <= rq8_q;
      rr9_q <= rr8_q;
      ss9_q <= ss8_q;
      sq9_q <= sq8_q;
      sr9_q <= sr8_q;
    end
  end

  // ---------------- S10: signed rounded q, r, s ----------------
  logic signed [RND_W-1:0] kq_pos, kr_pos, ks_pos;
  logic signed [RND_W-1:0] q10_q, r10_q, s10_q;
  logic [FRAC_BITS-1:0]    eq_q, er_q, es_q;

  assign kq_pos = signed'({1'b0, rq9_q.k});
  assign kr_pos = signed'({1'b0, rr9_q.k});
  assign ks_pos = signed'({1'b0, rs9_q.k});

  always_ff @(posedge clk_i) begin
    if (adv[10]) begin
      q10_q <= sq9_q ? -kq_pos : kq_pos;
      r10_q <= sr9_q ? -kr_pos : kr_pos;
      s10_q <= ss9_q ? -ks_pos : ks_pos;
      eq_q  <= rq9_q.err;
      er_q  <= rr9_q.err;
      es_q  <= rs9_q.err;
    end
  end

  // ---------------- S11: recompute coordinate with the largest error ----------------
  logic signed [HEX_W-1:0] hq_d, hr_d, hq_q, hr_q;

  always_comb begin
    hq_d = HEX_W'(q10_q);
    hr_d = HEX_W'(r10_q);
    priority if (eq_q > er_q && eq_q > es_q) begin
      hq_d = -HEX_W'(r10_q) - HEX_W'(s10_q);
    end else if (er_q > es_q) begin
      hr_d = -HEX_W'(q10_q) - HEX_W'(s10_q);
    end else begin
      // s has the largest error or shares it: q and r stay as rounded
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[11]) begin
      hq_q <= hq_d;
      hr_q <= hr_d;
    end
  end

  // ---------------- S12: magnitudes and saturation ----------------
  logic signed [HEX_W-1:0] qr_sum_q;
  logic [HEX_W-1:0]        nhq, nhr, aq12_q, ar12_q;
  logic signed [OUT_W-1:0] satq_d, satr_d, satq12_q, satr12_q;

  assign nhq = -hq_q;
  assign nhr = -hr_q;

  // out of range when the bits above the output sign are not a sign extension
  always_comb begin
    if (hq_q[HEX_W-1:OUT_W-1] == '0 || hq_q[HEX_W-1:OUT_W-1] == '1) begin
      satq_d = hq_q[OUT_W-1:0];
    end else begin
      satq_d = hq_q[HEX_W-1] ? signed'({1'b1, {(OUT_W-1){1'b0}}})
                             : signed'({1'b0, {(OUT_W-1){1'b1}}});
    end
    if (hr_q[HEX_W-1:OUT_W-1] == '0 || hr_q[HEX_W-1:OUT_W-1] == '1) begin
      satr_d = hr_q[OUT_W-1:0];
    end else begin
      satr_d = hr_q[HEX_W-1] ? signed'({1'b1, {(OUT_W-1){1'b0}}})
                             : signed'({1'b0, {(OUT_W-1){1'b1}}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[12]) begin
      qr_sum_q <= hq_q + hr_q;
      aq12_q   <= hq_q[HEX_W-1] ? nhq : hq_q;
      ar12_q   <= hr_q[HEX_W-1] ? nhr : hr_q;
      satq12_q <= satq_d;
      satr12_q <= satr_d;
    end
  end

  // ---------------- S13: partial distance ----------------
  logic [HEX_W-1:0]        nqr, aqr_q;
  logic [DIST_W-1:0]       part_q;
  logic signed [OUT_W-1:0] satq13_q, satr13_q;

  assign nqr = -qr_sum_q;

  always_ff @(posedge clk_i) begin
    if (adv[13]) begin
      part_q   <= DIST_W'(aq12_q) + DIST_W'(ar12_q);
      aqr_q    <= qr_sum_q[HEX_W-1] ? nqr : qr_sum_q;
      satq13_q <= satq12_q;
      satr13_q <= satr12_q;
    end
  end

  // ---------------- S14: distance compare, output register ----------------
  logic [DIST_W-1:0] twice_dist;
  logic [DIST_W-1:0] hex_dist;

  assign twice_dist = part_q + DIST_W'(aqr_q);
  assign hex_dist   = twice_dist >> 1;

  always_ff @(posedge clk_i) begin
    if (adv[14]) begin
      hex_q_o       <= satq13_q;
      hex_r_o       <= satr13_q;
      inside_grid_o <= (hex_dist <= DIST_W'(rad_q));
    end
  end

  // ---------------- checks ----------------
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_stall_i && (&v_q)))
    else $error("input stalled while a stage is empty or the output drains");

  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !(out_valid_o && !out_stall_i))
      |=> ($countones(v_q) == $past($countones(v_q)) + 1))
    else $error("accepted transaction not tracked in stage valids");

  a_drain_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !(in_valid_i && !in_stall_o))
      |=> ($countones(v_q) == $past($countones(v_q)) - 1))
    else $error("delivered transaction not removed from stage valids");

endmodule

`default_nettype wire
